// ===== design/h2fd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h2fd_pkg
// Shared types, constants and the preface table of the HTTP/2 frame
// delineator.
// ----------------------------------------------------------------------------
package h2fd_pkg;

    localparam int unsigned LEN_W     = 24;
    localparam int unsigned SIZE_W    = 25;
    localparam int unsigned POS_W     = 5;
    localparam int unsigned HIDX_W    = 4;

    localparam logic [POS_W-1:0]  SAMPLE_LAST  = 5'd4;
    localparam logic [POS_W-1:0]  PREFACE_LAST = 5'd23;
    localparam logic [HIDX_W-1:0] HEADER_LAST  = 4'd8;
    localparam logic [HIDX_W-1:0] HIDX_KIND    = 4'd3;
    localparam logic [HIDX_W-1:0] HIDX_LIMIT   = 4'd4;
    localparam logic [7:0]        SETTINGS_KIND = 8'd4;

    localparam logic [SIZE_W-1:0] SIZE_PLAIN   = 25'd9;
    localparam logic [SIZE_W-1:0] SIZE_PREFACE = 25'd33;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_OVER  = 2'd1,
        ST_PROTO = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        PH_CAND    = 5'b00001,
        PH_PREFACE = 5'b00010,
        PH_HEADER  = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_DEAD    = 5'b10000
    } t_phase;

    typedef struct packed {
        logic              valid;
        t_status           status;
        logic [SIZE_W-1:0] unit_size;
        logic              had_preface;
    } t_beat;

    // Connection preface "PRI * HTTP/2.0\r\n\r\nSM\r\n\r\n"
    function automatic logic [7:0] preface_byte(input logic [POS_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            5'd0:  b = 8'h50;
            5'd1:  b = 8'h52;
            5'd2:  b = 8'h49;
            5'd3:  b = 8'h20;
            5'd4:  b = 8'h2a;
            5'd5:  b = 8'h20;
            5'd6:  b = 8'h48;
            5'd7:  b = 8'h54;
            5'd8:  b = 8'h54;
            5'd9:  b = 8'h50;
            5'd10: b = 8'h2f;
            5'd11: b = 8'h32;
            5'd12: b = 8'h2e;
            5'd13: b = 8'h30;
            5'd14: b = 8'h0d;
            5'd15: b = 8'h0a;
            5'd16: b = 8'h0d;
            5'd17: b = 8'h0a;
            5'd18: b = 8'h53;
            5'd19: b = 8'h4d;
            5'd20: b = 8'h0d;
            5'd21: b = 8'h0a;
            5'd22: b = 8'h0d;
            5'd23: b = 8'h0a;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== design/h2fd_parse_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h2fd_parse_core
// Parser state and the single-pass next-state logic for one stream byte.
// ----------------------------------------------------------------------------
module h2fd_parse_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_advance,
    input  logic [7:0]               i_byte,
    input  logic [h2fd_pkg::LEN_W-1:0] i_max_len,
    output h2fd_pkg::t_beat          o_beat
);
    import h2fd_pkg::*;

    t_phase             r_phase, n_phase;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [LEN_W-1:0]   r_rem, n_rem;
    logic               r_pre, n_pre;

    logic               over;
    logic               do_hdr;
    logic [HIDX_W-1:0]  hdr_idx;
    logic [2:0]         cand_pos;
    logic [POS_W-1:0]   pre_pos;
    logic               done;
    logic               err;
    t_status            err_code;

    assign over = (i_max_len != '0) && (r_len > i_max_len);

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_len    = r_len;
        n_rem    = r_rem;
        n_pre    = r_pre;
        do_hdr   = 1'b0;
        hdr_idx  = '0;
        done     = 1'b0;
        err      = 1'b0;
        err_code = ST_PROTO;
        cand_pos = (r_pos >= 5'd5) ? 3'(SAMPLE_LAST) : r_pos[2:0];
        pre_pos  = (r_pos > PREFACE_LAST) ? PREFACE_LAST : r_pos;

        case (r_phase)
            PH_CAND: begin
                if (i_byte == preface_byte(POS_W'(cand_pos))
                        && POS_W'(cand_pos) == SAMPLE_LAST) begin
                    n_pre   = 1'b1;
                    n_len   = '0;
                    n_phase = PH_PREFACE;
                    n_pos   = SAMPLE_LAST + 5'd1;
                end else begin
                    if (i_byte != preface_byte(POS_W'(cand_pos))) begin
                        n_phase = PH_HEADER;
                    end
                    do_hdr  = 1'b1;
                    hdr_idx = HIDX_W'(cand_pos);
                end
            end
            PH_PREFACE: begin
                if (i_byte != preface_byte(pre_pos)) begin
                    err = 1'b1;
                end else if (pre_pos == PREFACE_LAST) begin
                    n_phase = PH_HEADER;
                    n_pos   = '0;
                end else begin
                    n_pos = pre_pos + 5'd1;
                end
            end
            PH_HEADER: begin
                do_hdr  = 1'b1;
                hdr_idx = (r_pos > POS_W'(HEADER_LAST)) ? HEADER_LAST : r_pos[HIDX_W-1:0];
            end
            PH_PAYLOAD: begin
                if (r_rem <= 24'd1) begin
                    n_rem = '0;
                    done  = 1'b1;
                end else begin
                    n_rem = r_rem - 24'd1;
                end
            end
            default: ;
        endcase

        // Frame header byte handling
        if (do_hdr) begin
            if (hdr_idx < HIDX_KIND) begin
                n_len = {r_len[LEN_W-9:0], i_byte};
                n_pos = POS_W'(hdr_idx) + 5'd1;
            end else if (hdr_idx == HIDX_KIND) begin
                if (r_pre && i_byte != SETTINGS_KIND) begin
                    err = 1'b1;
                end else if (r_pre && over) begin
                    err      = 1'b1;
                    err_code = ST_OVER;
                end else begin
                    n_pos = POS_W'(hdr_idx) + 5'd1;
                end
            end else if (hdr_idx == HIDX_LIMIT) begin
                if (!r_pre && over) begin
                    err      = 1'b1;
                    err_code = ST_OVER;
                end else begin
                    n_pos = POS_W'(hdr_idx) + 5'd1;
                end
            end else if (hdr_idx == HEADER_LAST) begin
                if (r_len == '0) begin
                    done = 1'b1;
                end else begin
                    n_rem   = r_len;
                    n_phase = PH_PAYLOAD;
                end
            end else begin
                n_pos = POS_W'(hdr_idx) + 5'd1;
            end
        end

        o_beat = '0;
        if (err) begin
            o_beat.valid  = 1'b1;
            o_beat.status = err_code;
            n_phase       = PH_DEAD;
        end else if (done) begin
            o_beat.valid       = 1'b1;
            o_beat.status      = ST_DONE;
            o_beat.unit_size   = SIZE_W'(r_len) + (r_pre ? SIZE_PREFACE : SIZE_PLAIN);
            o_beat.had_preface = r_pre;
            // start the next unit
            n_phase = PH_CAND;
            n_pos   = '0;
            n_len   = '0;
            n_rem   = '0;
            n_pre   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CAND;
            r_pos   <= '0;
            r_len   <= '0;
            r_rem   <= '0;
            r_pre   <= 1'b0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_rem   <= n_rem;
            r_pre   <= n_pre;
        end
    end

endmodule

// ===== design/h2fd_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h2fd_out_reg
// Result register: holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module h2fd_out_reg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_advance,
    input  h2fd_pkg::t_beat             i_beat,
    input  logic                        i_out_stall,
    output logic                        o_free,
    output logic                        o_out_valid,
    output h2fd_pkg::t_status           o_status,
    output logic [h2fd_pkg::SIZE_W-1:0] o_unit_size,
    output logic                        o_had_preface
);
    import h2fd_pkg::*;

    logic              r_valid;
    t_status           r_status;
    logic [SIZE_W-1:0] r_size;
    logic              r_pre;

    assign o_free = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_advance && i_beat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_advance && i_beat.valid) begin
            r_status <= i_beat.status;
            r_size   <= i_beat.unit_size;
            r_pre    <= i_beat.had_preface;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_status      = r_status;
    assign o_unit_size   = r_size;
    assign o_had_preface = r_pre;

endmodule

// ===== design/http2_frame_delineator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http2_frame_delineator_unit
// Finds HTTP/2 unit boundaries (optional connection preface plus one frame)
// in a byte stream and reports unit size, oversize or protocol errors.
// ----------------------------------------------------------------------------
//
// Channel  | Dir | Handshake                  | Payload
// ---------+-----+----------------------------+----------------------------------
// input    | in  | i_in_valid / o_in_stall    | i_data_byte[7:0]
// output   | out | o_out_valid / i_out_stall  | o_status, o_unit_size, o_had_preface
// config   | in  | i_cfg_we                   | i_cfg_data[23:0] (max payload length)
//
// One byte is accepted per clock while o_in_stall is low. An accepted byte
// sits in the input register while the parser works on it, and its result
// (if any) is loaded into the result register once that register is free.
// Throughput is set by the result register: bytes stall only while a result
// beat is held by i_out_stall. Reset (synchronous, active low) returns to the
// unit boundary with the limit disabled. After an error or oversize beat the
// parser stays silent until reset.
// ----------------------------------------------------------------------------
module http2_frame_delineator_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [h2fd_pkg::LEN_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [7:0]                  i_data_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [1:0]                  o_status,
    output logic [h2fd_pkg::SIZE_W-1:0] o_unit_size,
    output logic                        o_had_preface
);
    import h2fd_pkg::*;

    logic [LEN_W-1:0]  r_limit;
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              out_free;
    logic              advance;
    t_beat             beat;
    t_status           status;

    // Limit register; the user writes it only while the parser is idle (not enforced here)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '0;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    // Advance the held byte whenever the result register can take a beat
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    // Input register: load a new beat whenever it is not held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_data_byte;
        end
    end

    h2fd_parse_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_in_byte),
        .i_max_len (r_limit),
        .o_beat    (beat)
    );

    h2fd_out_reg u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (advance),
        .i_beat        (beat),
        .i_out_stall   (i_out_stall),
        .o_free        (out_free),
        .o_out_valid   (o_out_valid),
        .o_status      (status),
        .o_unit_size   (o_unit_size),
        .o_had_preface (o_had_preface)
    );

    assign o_status = status;

endmodule

// ===== dv/http2_frame_delineator_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http2_frame_delineator_unit_test
// Self-checking bench for the HTTP/2 frame delineator. Byte beats are
// offered with random gaps and result beats are taken with random stalls.
// A byte-level tracker of the parser predicts every result beat; a short
// table of known units comes first, then random units under several payload
// limits, and the run closes with one randomly chosen fatal error followed
// by bytes that must stay silent.
// ----------------------------------------------------------------------------
module http2_frame_delineator_unit_test;
    import h2fd_pkg::*;

    // Expected content of one result beat.
    typedef struct packed {
        t_status           status;
        logic [SIZE_W-1:0] unit_size;
        logic              had_preface;
    } t_unit_report;

    // One row of the directed table. Rows marked TYPED carry the result beat
    // that their byte must produce; all others are left to the tracker.
    typedef struct packed {
        logic [7:0]   data;
        logic         check;
        t_unit_report report;
    } t_stim_row;

    // Fatal errors, one of which ends every run.
    typedef enum int {
        FAULT_PLAIN_OVER,
        FAULT_SETTINGS_OVER,
        FAULT_NOT_SETTINGS,
        FAULT_PREFACE_BREAK,
        FAULT_NEAR_MISS
    } t_fault;

    localparam logic PREDICT = 1'b0;
    localparam logic TYPED   = 1'b1;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned PHASE_BYTES = 290;
    localparam int unsigned LONG_HOLD   = 400;
    localparam int unsigned TAIL_BYTES  = 30;
    localparam int unsigned MAX_LEN     = 300;

    // "PRI * HTTP/2.0\r\n\r\nSM\r\n\r\n"
    localparam logic [8*24-1:0] PREFACE_STR =
        "PRI * HTTP/2.0\015\012\015\012SM\015\012\015\012";

    localparam t_unit_report NO_REPORT = '{ST_DONE, 25'd0, 1'b0};

    localparam t_stim_row DIRECTED_ROWS [42] = '{
        // plain frame, zero length, all-ones type and stream id
        '{8'h00, PREDICT, NO_REPORT}, '{8'h00, PREDICT, NO_REPORT},
        '{8'h00, PREDICT, NO_REPORT}, '{8'hFF, PREDICT, NO_REPORT},
        '{8'h00, PREDICT, NO_REPORT}, '{8'hFF, PREDICT, NO_REPORT},
        '{8'hFF, PREDICT, NO_REPORT}, '{8'hFF, PREDICT, NO_REPORT},
        '{8'hFF, TYPED, '{ST_DONE, 25'd9, 1'b0}},
        // connection preface: "PRI * HTTP/2.0"
        '{8'h50, PREDICT, NO_REPORT}, '{8'h52, PREDICT, NO_REPORT},
        '{8'h49, PREDICT, NO_REPORT}, '{8'h20, PREDICT, NO_REPORT},
        '{8'h2a, PREDICT, NO_REPORT}, '{8'h20, PREDICT, NO_REPORT},
        '{8'h48, PREDICT, NO_REPORT}, '{8'h54, PREDICT, NO_REPORT},
        '{8'h54, PREDICT, NO_REPORT}, '{8'h50, PREDICT, NO_REPORT},
        '{8'h2f, PREDICT, NO_REPORT}, '{8'h32, PREDICT, NO_REPORT},
        '{8'h2e, PREDICT, NO_REPORT}, '{8'h30, PREDICT, NO_REPORT},
        // "\r\n\r\nSM\r\n\r\n"
        '{8'h0d, PREDICT, NO_REPORT}, '{8'h0a, PREDICT, NO_REPORT},
        '{8'h0d, PREDICT, NO_REPORT}, '{8'h0a, PREDICT, NO_REPORT},
        '{8'h53, PREDICT, NO_REPORT}, '{8'h4d, PREDICT, NO_REPORT},
        '{8'h0d, PREDICT, NO_REPORT}, '{8'h0a, PREDICT, NO_REPORT},
        '{8'h0d, PREDICT, NO_REPORT}, '{8'h0a, PREDICT, NO_REPORT},
        // empty SETTINGS frame closes the preface unit
        '{8'h00, PREDICT, NO_REPORT}, '{8'h00, PREDICT, NO_REPORT},
        '{8'h00, PREDICT, NO_REPORT}, '{8'h04, PREDICT, NO_REPORT},
        '{8'h00, PREDICT, NO_REPORT}, '{8'h00, PREDICT, NO_REPORT},
        '{8'h00, PREDICT, NO_REPORT}, '{8'h00, PREDICT, NO_REPORT},
        '{8'h00, TYPED, '{ST_DONE, 25'd33, 1'b1}}
    };

    // DUT ports; every input starts at a known value.
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [LEN_W-1:0]  i_cfg_data  = '0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    logic [7:0]        i_data_byte = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [1:0]        o_status;
    logic [SIZE_W-1:0] o_unit_size;
    logic              o_had_preface;

    // Tracker state, a private copy of the parser's state and its limit.
    t_phase            trk_phase;
    logic [POS_W-1:0]  trk_pos;
    logic [LEN_W-1:0]  trk_len;
    logic [LEN_W-1:0]  trk_left;
    logic              trk_preface;
    logic [7:0]        trk_kind;
    logic [LEN_W-1:0]  limit_shadow;

    t_unit_report      expected_units [$];
    int unsigned       mismatch_count = 0;
    int unsigned       bytes_sent     = 0;
    int unsigned       cycle_count    = 0;
    bit                tx_calm        = 1'b0;
    bit                rx_calm        = 1'b0;

    http2_frame_delineator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_byte   (i_data_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_unit_size   (o_unit_size),
        .o_had_preface (o_had_preface)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Tracker
    // ------------------------------------------------------------------
    function automatic logic [7:0] preface_at(input int unsigned idx);
        return PREFACE_STR[8*(23-idx) +: 8];
    endfunction

    function automatic void restart_unit();
        trk_phase   = PH_CAND;
        trk_pos     = '0;
        trk_len     = '0;
        trk_left    = '0;
        trk_preface = 1'b0;
        trk_kind    = '0;
    endfunction

    function automatic bit over_limit();
        return limit_shadow != '0 && trk_len > limit_shadow;
    endfunction

    // Error and oversize beats carry no size; the parser then goes quiet.
    function automatic bit raise_fault(input t_status code, output t_unit_report rep);
        rep       = NO_REPORT;
        rep.status = code;
        trk_phase = PH_DEAD;
        return 1'b1;
    endfunction

    function automatic bit close_unit(output t_unit_report rep);
        rep.status      = ST_DONE;
        rep.unit_size   = SIZE_W'(trk_len) + (trk_preface ? SIZE_PREFACE : SIZE_PLAIN);
        rep.had_preface = trk_preface;
        restart_unit();
        return 1'b1;
    endfunction

    function automatic bit header_step(input logic [HIDX_W-1:0] idx, input logic [7:0] b,
                                       output t_unit_report rep);
        rep = NO_REPORT;
        if (idx < HIDX_KIND) begin
            trk_len = {trk_len[15:0], b};
        end else if (idx == HIDX_KIND) begin
            // after a preface the type byte decides: SETTINGS first, then the limit
            trk_kind = b;
            if (trk_preface && trk_kind != SETTINGS_KIND) return raise_fault(ST_PROTO, rep);
            if (trk_preface && over_limit()) return raise_fault(ST_OVER, rep);
        end else if (idx == HIDX_LIMIT) begin
            if (!trk_preface && over_limit()) return raise_fault(ST_OVER, rep);
        end else if (idx == HEADER_LAST) begin
            if (trk_len == '0) return close_unit(rep);
            trk_left  = trk_len;
            trk_phase = PH_PAYLOAD;
            return 1'b0;
        end
        trk_pos = {1'b0, idx + 4'd1};
        return 1'b0;
    endfunction

    // Advance the tracker by one byte; return 1 when a result beat is due.
    function automatic bit track_byte(input logic [7:0] b, output t_unit_report rep);
        logic [POS_W-1:0] p;
        rep = NO_REPORT;
        p   = trk_pos;
        case (trk_phase)
            PH_CAND: begin
                // the first five bytes double as header bytes until they
                // turn out to be the preface
                if (p > SAMPLE_LAST) p = SAMPLE_LAST;
                if (b == preface_at(p) && p == SAMPLE_LAST) begin
                    trk_preface = 1'b1;
                    trk_len     = '0;
                    trk_kind    = '0;
                    trk_phase   = PH_PREFACE;
                    trk_pos     = SAMPLE_LAST + 5'd1;
                    return 1'b0;
                end
                if (b != preface_at(p)) trk_phase = PH_HEADER;
                return header_step(p[HIDX_W-1:0], b, rep);
            end
            PH_PREFACE: begin
                if (b != preface_at(p)) return raise_fault(ST_PROTO, rep);
                if (p == PREFACE_LAST) begin
                    trk_phase = PH_HEADER;
                    trk_pos   = '0;
                end else begin
                    trk_pos = p + 5'd1;
                end
                return 1'b0;
            end
            PH_HEADER: begin
                return header_step(p[HIDX_W-1:0], b, rep);
            end
            PH_PAYLOAD: begin
                if (trk_left <= 24'd1) return close_unit(rep);
                trk_left = trk_left - 24'd1;
                return 1'b0;
            end
            default: begin
                return 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Wait draw shared by both sides; calm stretches give back-to-back beats.
    function automatic int unsigned draw_wait(inout bit calm);
        if ($urandom_range(47) == 0) calm = !calm;
        if (calm || $urandom_range(99) < 35) return 0;
        return $urandom_range(16, 1);
    endfunction

    task automatic log_mismatch(input string what);
        mismatch_count++;
        $display("%0t: mismatch: %s", $time, what);
    endtask

    // Offer one byte beat and hold it until the DUT takes it. Drop valid only
    // when a gap follows, so it is never lowered and raised in one step.
    task automatic offer_byte(input logic [7:0] b);
        int unsigned gap;
        gap = draw_wait(tx_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        t_unit_report rep;
        offer_byte(b);
        if (track_byte(b, rep)) expected_units.push_back(rep);
    endtask

    task automatic send_preface(input int unsigned count);
        int unsigned k;
        for (k = 0; k < count; k++) send_byte(preface_at(k));
    endtask

    // Nine header bytes: big-endian length, type, flags, stream id.
    task automatic send_header(input logic [LEN_W-1:0] len, input logic [7:0] kind);
        int unsigned k;
        send_byte(len[23:16]);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        send_byte(kind);
        for (k = 0; k < 5; k++) send_byte(8'($urandom));
    endtask

    // Mostly short payloads; hit the limit itself now and then.
    function automatic logic [LEN_W-1:0] pick_length(input logic [LEN_W-1:0] limit);
        int unsigned cap;
        int unsigned r;
        cap = (limit == '0 || limit > MAX_LEN) ? MAX_LEN : limit;
        r   = $urandom_range(99);
        if (limit != '0 && limit <= MAX_LEN && r < 10) return limit;
        if (r < 55) return LEN_W'($urandom_range(cap < 12 ? cap : 12));
        if (r < 93) return LEN_W'($urandom_range(cap < 64 ? cap : 64));
        return LEN_W'($urandom_range(cap));
    endfunction

    task automatic send_frame_unit(input logic [LEN_W-1:0] limit);
        bit               with_preface;
        logic [LEN_W-1:0] len;
        int unsigned      k;
        with_preface = ($urandom_range(9) < 3);
        len          = pick_length(limit);
        if (with_preface) send_preface(24);
        send_header(len, with_preface ? SETTINGS_KIND : 8'($urandom));
        for (k = 0; k < len; k++) send_byte(8'($urandom));
    endtask

    // Lower valid, hold until every result beat is in, then let the
    // pipeline empty before anything touches the limit register.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_units.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LEN_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        limit_shadow = value;
    endtask

    // One fatal error per run; the parser stays silent afterwards.
    task automatic send_closing_fault();
        t_fault           kind;
        logic [LEN_W-1:0] lim;
        logic [LEN_W-1:0] len;
        logic [7:0]       b;
        int unsigned      cut;
        int unsigned      k;
        kind = t_fault'($urandom_range(4));
        lim  = ($urandom_range(3) == 0) ? 24'hFFFFFE : 24'($urandom_range(24'hFFFFFE, 1));
        len  = (lim == 24'hFFFFFE) ? 24'hFFFFFF : 24'($urandom_range(24'hFFFFFF, lim + 1));
        // keep the limit below any length that starts with 'P'
        if (kind == FAULT_NEAR_MISS) lim = 24'($urandom_range(24'h4FFFFF, 1));
        write_limit(lim);
        case (kind)
            FAULT_PLAIN_OVER: begin
                send_header(len, 8'($urandom));
            end
            FAULT_SETTINGS_OVER: begin
                send_preface(24);
                send_header(len, SETTINGS_KIND);
            end
            FAULT_NOT_SETTINGS: begin
                send_preface(24);
                do b = 8'($urandom); while (b == SETTINGS_KIND);
                send_header(24'($urandom_range(MAX_LEN)), b);
            end
            FAULT_PREFACE_BREAK: begin
                cut = $urandom_range(23, 5);
                send_preface(cut);
                do b = 8'($urandom); while (b == preface_at(cut));
                send_byte(b);
            end
            default: begin
                // plain frame whose first bytes look like the preface
                cut = $urandom_range(4, 1);
                send_preface(cut);
                do b = 8'($urandom); while (b == preface_at(cut));
                send_byte(b);
                for (k = cut + 1; k < 9; k++) send_byte(8'($urandom));
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls per beat, two long hold-offs that back
    // the parser up into its input.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int unsigned hold;
        int unsigned beats_taken;
        beats_taken = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (beats_taken == 3 || beats_taken == 30) hold = LONG_HOLD;
            else hold = draw_wait(rx_calm);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid === 1'b1 && !i_out_stall));
            beats_taken++;
        end
    end

    // Compare every accepted result beat with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_unit_report want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (expected_units.size() == 0) begin
                log_mismatch($sformatf("unexpected beat status=%0d size=%0d preface=%0b",
                                       o_status, o_unit_size, o_had_preface));
            end else begin
                want = expected_units.pop_front();
                if (o_status !== want.status)
                    log_mismatch($sformatf("status %0d, want %0d", o_status, want.status));
                if (o_unit_size !== want.unit_size)
                    log_mismatch($sformatf("unit_size %0d, want %0d",
                                           o_unit_size, want.unit_size));
                if (o_had_preface !== want.had_preface)
                    log_mismatch($sformatf("had_preface %0b, want %0b",
                                           o_had_preface, want.had_preface));
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [LEN_W-1:0] limits [5];
        t_unit_report     scratch;
        int unsigned      ph;
        int unsigned      i;
        int unsigned      phase_start;

        restart_unit();
        limit_shadow = '0;

        // hold reset low, then release it
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // limit per phase: off, widest, tightest, two random ones
        limits = '{24'd0, 24'hFFFFFF, 24'd1, 24'($urandom_range(48, 2)),
                   24'($urandom_range(24'hFFFFFE, 49))};
        write_limit(limits[0]);

        // directed table: typed rows push their own beat, the tracker still
        // advances so later rows stay in step
        for (i = 0; i < 42; i++) begin
            if (DIRECTED_ROWS[i].check == TYPED) begin
                offer_byte(DIRECTED_ROWS[i].data);
                void'(track_byte(DIRECTED_ROWS[i].data, scratch));
                expected_units.push_back(DIRECTED_ROWS[i].report);
            end else begin
                send_byte(DIRECTED_ROWS[i].data);
            end
        end

        // random units; drain fully before every limit change
        for (ph = 0; ph < 5; ph++) begin
            if (ph > 0) begin
                drain_results();
                write_limit(limits[ph]);
            end
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) send_frame_unit(limits[ph]);
        end

        // close with one fatal error, then check that the parser stays quiet
        drain_results();
        send_closing_fault();
        for (i = 0; i < TAIL_BYTES; i++) send_byte(8'($urandom));
        drain_results();

        if (mismatch_count == 0 && expected_units.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/h2fd_pkg.sv
design/h2fd_parse_core.sv
design/h2fd_out_reg.sv
design/http2_frame_delineator_unit.sv
dv/http2_frame_delineator_unit_test.sv
